>>> design/cosine_similarity_stream_top_defines.svh
// Assertion macros for the cosine similarity stream block.
// Used by the datapath and controller; expects clk and rst in scope.
`ifndef COSINE_SIMILARITY_STREAM_TOP_DEFINES_SVH
`define COSINE_SIMILARITY_STREAM_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CSS_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("css assertion failed");
`define CSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("css assertion failed");
`else
`define CSS_ASSERT(label, ante, cons)
`define CSS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> design/css_pkg.sv
// Shared types and constants for the cosine similarity stream block.
// No dependencies.
package css_pkg;

  localparam int ELEM_W   = 16;
  localparam int PROD_W   = 2 * ELEM_W;
  localparam int DOT_W    = 43;
  localparam int NORM_W   = 41;
  localparam int SCORE_W  = 16;
  localparam int LIMB_W   = 32;
  localparam int MAC_W    = 128;
  localparam int PRD_W    = 2 * NORM_W;
  localparam int MAX_DIM_DEF = 1024;

  localparam logic [DOT_W-1:0]   DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
  localparam logic [DOT_W-1:0]   DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};
  localparam logic [NORM_W-1:0]  NORM_MAX = {NORM_W{1'b1}};
  localparam logic [SCORE_W-1:0] SRCH_TOP = 16'd32768;
  localparam logic [SCORE_W-1:0] SCORE_POS_MAX = 16'd32767;

  typedef enum logic [1:0] {
    MS_SQ,
    MS_PR,
    MS_ODD,
    MS_LHS
  } mul_src_t;

  typedef enum logic [3:0] {
    S_ACC,
    S_DRAIN,
    S_LATCH,
    S_SQ,
    S_SQW,
    S_PR,
    S_PRW,
    S_CHK,
    S_ODD,
    S_ODW,
    S_LHS,
    S_LHW,
    S_CMP,
    S_DONE
  } css_state_t;

  typedef struct packed {
    logic     take;
    logic     latch;
    logic     acc_clr;
    logic     mul_en;
    mul_src_t src;
    logic [1:0] i;
    logic [1:0] j;
    logic     mac_clr;
    logic     rhs_ld;
    logic     prod_ld;
    logic     srch_init;
    logic     odd2_ld;
    logic     srch_upd;
    logic     out_ld;
  } css_cmd_t;

  typedef struct packed {
    logic norm_zero;
    logic lo_lt_hi;
    logic out_busy;
  } css_stat_t;

endpackage

>>> design/css_dpath.sv
// Datapath: element products, accumulators, shared 32x32 multiply-accumulate,
// binary search for the score and the output register. Depends on css_pkg.
`include "cosine_similarity_stream_top_defines.svh"
module css_dpath #(
  parameter int MAX_DIM = css_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  css_pkg::css_cmd_t                 cmd,
  output css_pkg::css_stat_t                st,
  input  logic [2*css_pkg::ELEM_W-1:0]      s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [css_pkg::SCORE_W-1:0]       m_tdata,
  output logic [1:0]                        m_tuser
);
  import css_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM + 2);

  logic signed [ELEM_W-1:0] a_in, b_in;
  logic signed [PROD_W-1:0] p_ab, p_aa, p_bb;
  logic                     pvld;

  logic signed [DOT_W-1:0]  dot;
  logic [NORM_W-1:0]        na, nb;
  logic [CNT_W-1:0]         cnt;
  logic [DOT_W:0]           dot_sum;
  logic [NORM_W:0]          na_sum, nb_sum;

  logic                     fin_neg, fin_zero, fin_ovf;
  logic [DOT_W-1:0]         fin_mag;

  logic [LIMB_W-1:0]        mx, my;
  logic [1:0]               msh;
  logic [2*LIMB_W-1:0]      mul_q;
  logic [1:0]               shift_q;
  logic                     addv_q;
  logic [MAC_W-1:0]         mac, mac_sum, addend;
  logic [MAC_W-1:0]         rhs;
  logic [PRD_W-1:0]         prod;
  logic [2*LIMB_W-1:0]      mag64, na64, nb64;
  logic [3*LIMB_W-1:0]      prod96;

  logic [SCORE_W-1:0]       lo, hi, mid, odd;
  logic [SCORE_W:0]         mid_sum, odd_w;
  logic [LIMB_W-1:0]        odd2;
  logic [SCORE_W-1:0]       score_next;

  assign a_in = s_tdata[ELEM_W-1:0];
  assign b_in = s_tdata[2*ELEM_W-1:ELEM_W];

  always_ff @(posedge clk) begin
    p_ab <= a_in * b_in;
    p_aa <= a_in * a_in;
    p_bb <= b_in * b_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvld <= 1'b0;
    end else begin
      pvld <= cmd.take;
    end
  end

  assign dot_sum = {dot[DOT_W-1], dot} + (DOT_W+1)'(p_ab);
  assign na_sum  = {1'b0, na} + (NORM_W+1)'(unsigned'(p_aa));
  assign nb_sum  = {1'b0, nb} + (NORM_W+1)'(unsigned'(p_bb));

  always_ff @(posedge clk) begin
    if (rst || cmd.acc_clr) begin
      dot <= '0;
      na  <= '0;
      nb  <= '0;
      cnt <= '0;
    end else if (pvld) begin
      if (dot_sum[DOT_W] != dot_sum[DOT_W-1]) begin
        dot <= dot_sum[DOT_W] ? DOT_MIN : DOT_MAX;
      end else begin
        dot <= dot_sum[DOT_W-1:0];
      end
      na <= na_sum[NORM_W] ? NORM_MAX : na_sum[NORM_W-1:0];
      nb <= nb_sum[NORM_W] ? NORM_MAX : nb_sum[NORM_W-1:0];
      if (cnt <= CNT_W'(MAX_DIM)) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      fin_neg  <= dot[DOT_W-1];
      fin_mag  <= dot[DOT_W-1] ? (~dot + 1'b1) : dot;
      fin_zero <= (na == '0) || (nb == '0);
      fin_ovf  <= cnt > CNT_W'(MAX_DIM);
    end
  end

  assign mag64  = (2*LIMB_W)'(fin_mag);
  assign na64   = (2*LIMB_W)'(na);
  assign nb64   = (2*LIMB_W)'(nb);
  assign prod96 = (3*LIMB_W)'(prod);

  assign mid_sum = {1'b0, lo} + {1'b0, hi} + 1'b1;
  assign mid     = mid_sum[SCORE_W:1];
  assign odd_w   = {mid, 1'b0} - 1'b1;
  assign odd     = odd_w[SCORE_W-1:0];

  always_comb begin
    mx  = '0;
    my  = '0;
    msh = '0;
    unique case (cmd.src)
      MS_SQ: begin
        mx  = cmd.i[0] ? mag64[2*LIMB_W-1:LIMB_W] : mag64[LIMB_W-1:0];
        my  = cmd.j[0] ? mag64[2*LIMB_W-1:LIMB_W] : mag64[LIMB_W-1:0];
        msh = cmd.i + cmd.j;
      end
      MS_PR: begin
        mx  = cmd.i[0] ? na64[2*LIMB_W-1:LIMB_W] : na64[LIMB_W-1:0];
        my  = cmd.j[0] ? nb64[2*LIMB_W-1:LIMB_W] : nb64[LIMB_W-1:0];
        msh = cmd.i + cmd.j;
      end
      MS_ODD: begin
        mx = LIMB_W'(odd);
        my = LIMB_W'(odd);
      end
      MS_LHS: begin
        case (cmd.i)
          2'd0:    mx = prod96[LIMB_W-1:0];
          2'd1:    mx = prod96[2*LIMB_W-1:LIMB_W];
          2'd2:    mx = prod96[3*LIMB_W-1:2*LIMB_W];
          default: mx = '0;
        endcase
        my  = odd2;
        msh = cmd.i;
      end
      default: begin
        mx = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_q   <= mx * my;
    shift_q <= msh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addv_q <= 1'b0;
    end else begin
      addv_q <= cmd.mul_en && (cmd.src != MS_ODD);
    end
  end

  assign addend  = MAC_W'(mul_q) << {shift_q, 5'b0};
  assign mac_sum = addv_q ? (mac + addend) : mac;

  always_ff @(posedge clk) begin
    if (cmd.mac_clr) begin
      mac <= '0;
    end else begin
      mac <= mac_sum;
    end
    if (cmd.rhs_ld) begin
      rhs <= {mac_sum[MAC_W-LIMB_W-1:0], {LIMB_W{1'b0}}};
    end
    if (cmd.prod_ld) begin
      prod <= mac_sum[PRD_W-1:0];
    end
    if (cmd.odd2_ld) begin
      odd2 <= mul_q[LIMB_W-1:0];
    end
    if (cmd.srch_init) begin
      lo <= '0;
      hi <= SRCH_TOP;
    end else if (cmd.srch_upd) begin
      if (mac <= rhs) begin
        lo <= mid;
      end else begin
        hi <= mid - 1'b1;
      end
    end
  end

  always_comb begin
    if (fin_zero) begin
      score_next = '0;
    end else if (fin_neg) begin
      score_next = ~lo + 1'b1;
    end else if (lo > SCORE_POS_MAX) begin
      score_next = SCORE_POS_MAX;
    end else begin
      score_next = lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_ld) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      m_tdata <= score_next;
      m_tuser <= {fin_ovf, fin_zero};
    end
  end

  assign st.norm_zero = (na == '0) || (nb == '0);
  assign st.lo_lt_hi  = lo < hi;
  assign st.out_busy  = m_tvalid && !m_tready;

  `CSS_ASSERT(a_upd_in_range, cmd.srch_upd, lo < hi)
  `CSS_ASSERT(a_latch_drained, cmd.latch, !pvld)
  `CSS_ASSERT_NEXT(a_zero_score, cmd.out_ld && fin_zero, m_tdata == '0 && m_tuser[0])
  `CSS_ASSERT_NEXT(a_acc_cleared, cmd.acc_clr, cnt == '0 && dot == '0)

endmodule

>>> design/css_ctrl.sv
// Controller: sequences accumulation, the multiply steps and the score search.
// Depends on css_pkg; drives the datapath through css_cmd_t.
`include "cosine_similarity_stream_top_defines.svh"
module css_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tlast,
  output logic               s_tready,
  input  css_pkg::css_stat_t st,
  output css_pkg::css_cmd_t  cmd
);
  import css_pkg::*;

  css_state_t state, state_next;
  logic [1:0] step, step_next;
  logic       take;

  assign take = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_ACC:   if (take && s_tlast) state_next = S_DRAIN;
      S_DRAIN: state_next = S_LATCH;
      S_LATCH: state_next = st.norm_zero ? S_DONE : S_SQ;
      S_SQ:    if (step == 2'd3) state_next = S_SQW;
      S_SQW:   state_next = S_PR;
      S_PR:    if (step == 2'd3) state_next = S_PRW;
      S_PRW:   state_next = S_CHK;
      S_CHK:   state_next = st.lo_lt_hi ? S_ODD : S_DONE;
      S_ODD:   state_next = S_ODW;
      S_ODW:   state_next = S_LHS;
      S_LHS:   if (step == 2'd2) state_next = S_LHW;
      S_LHW:   state_next = S_CMP;
      S_CMP:   state_next = S_CHK;
      S_DONE:  if (!st.out_busy) state_next = S_ACC;
      default: state_next = S_ACC;
    endcase
  end

  always_comb begin
    step_next = '0;
    if ((state == S_SQ || state == S_PR || state == S_LHS) && state_next == state) begin
      step_next = step + 1'b1;
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.src  = MS_SQ;
    s_tready = 1'b0;
    unique case (state)
      S_ACC: begin
        s_tready = 1'b1;
        cmd.take = take;
      end
      S_LATCH: begin
        cmd.latch   = 1'b1;
        cmd.mac_clr = 1'b1;
      end
      S_SQ: begin
        cmd.mul_en = 1'b1;
        cmd.src    = MS_SQ;
        cmd.i      = {1'b0, step[1]};
        cmd.j      = {1'b0, step[0]};
      end
      S_SQW: begin
        cmd.rhs_ld  = 1'b1;
        cmd.mac_clr = 1'b1;
      end
      S_PR: begin
        cmd.mul_en = 1'b1;
        cmd.src    = MS_PR;
        cmd.i      = {1'b0, step[1]};
        cmd.j      = {1'b0, step[0]};
      end
      S_PRW: begin
        cmd.prod_ld   = 1'b1;
        cmd.mac_clr   = 1'b1;
        cmd.srch_init = 1'b1;
      end
      S_ODD: begin
        cmd.mul_en = 1'b1;
        cmd.src    = MS_ODD;
      end
      S_ODW: begin
        cmd.odd2_ld = 1'b1;
      end
      S_LHS: begin
        cmd.mul_en = 1'b1;
        cmd.src    = MS_LHS;
        cmd.i      = step;
      end
      S_CMP: begin
        cmd.srch_upd = 1'b1;
        cmd.mac_clr  = 1'b1;
      end
      S_DONE: begin
        cmd.out_ld  = !st.out_busy;
        cmd.acc_clr = !st.out_busy;
      end
      default: begin
        cmd.src = MS_SQ;
      end
    endcase
  end

  `CSS_ASSERT(a_take_only_acc, take, state == S_ACC)
  `CSS_ASSERT_NEXT(a_last_drains, take && s_tlast, state == S_DRAIN && !s_tready)
  `CSS_ASSERT(a_step_bound, state == S_LHS, step != 2'd3)

endmodule

>>> design/cosine_similarity_stream_top.sv
// Cosine similarity of two streamed Q1.15 vectors; one element pair per cycle
// while s_tready is high. After the last beat the score is found by a binary
// search of at most 16 steps, each using the shared 32x32 multiply-accumulate;
// the search is skipped when a norm is zero. Input is held off until the score is loaded.
// Synchronous active-high reset clears accumulators, count and control.
module cosine_similarity_stream_top #(
  parameter int MAX_DIM = css_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [2*css_pkg::ELEM_W-1:0]  s_tdata,   // elem_a, elem_b
  input  logic                          s_tlast,   // last_elem
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [css_pkg::SCORE_W-1:0]   m_tdata,   // score
  output logic [1:0]                    m_tuser    // zero_norm, overflow
);
  import css_pkg::*;

  css_cmd_t  cmd;
  css_stat_t st;

  css_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  css_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
